### hw/rtl/tba_pkg.sv
// Shared types, constants and helpers of the timestamp bucket alignment block.
package tba_pkg;

  localparam int STAMP_BITS = 64;
  localparam int DATA_BITS = 64;
  localparam int WIDTH_BITS = 63;
  localparam int DVD_BITS = DATA_BITS + 1;
  localparam int INDEX_BITS = 8;
  localparam int EXT_SHIFT = DATA_BITS - STAMP_BITS;
  localparam int PIPE_DEPTH = DVD_BITS + 3;

  localparam logic [DATA_BITS-1:0] STAMP_MAX =
    (DATA_BITS'(1) << (STAMP_BITS - 1)) - DATA_BITS'(1);
  localparam logic [DATA_BITS-1:0] STAMP_MIN = ~STAMP_MAX;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_WIDTH  = 8'd0,
    REG_ORIGIN = 8'd1
  } reg_index_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  t;
    logic [WIDTH_BITS-1:0] w;
    logic                  neg_d;
    logic                  neg_o;
    logic                  inf;
    logic [DVD_BITS-1:0]   dvd_d;
    logic [DVD_BITS-1:0]   dvd_o;
    logic [WIDTH_BITS-1:0] rem_d;
    logic [WIDTH_BITS-1:0] rem_o;
  } tba_item_t;

  function automatic logic [DATA_BITS-1:0] sext_stamp(input logic [DATA_BITS-1:0] raw);
    logic signed [DATA_BITS-1:0] v;
    v = $signed(raw << EXT_SHIFT);
    return DATA_BITS'(v >>> EXT_SHIFT);
  endfunction

endpackage

### hw/rtl/tba_front.sv
// Input stage: sign extension, origin offset and operand magnitudes.
module tba_front
  import tba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DATA_BITS-1:0]  stamp,
  input  logic [WIDTH_BITS-1:0] width_cfg,
  input  logic [DATA_BITS-1:0]  origin_cfg,
  output logic                  out_valid,
  output tba_item_t             out_item
);

  logic [DATA_BITS-1:0]  t;
  logic [DATA_BITS-1:0]  org;
  logic [WIDTH_BITS-1:0] w;
  logic [DATA_BITS+1:0]  d;
  logic [DATA_BITS+1:0]  ad;
  logic [DVD_BITS-1:0]   ox;
  logic [DVD_BITS-1:0]   aox;
  tba_item_t             item_next;

  always_comb begin
    t = sext_stamp(stamp);
    org = sext_stamp(origin_cfg);
    w = (width_cfg == '0) ? WIDTH_BITS'(1) : width_cfg;
    d = {t[DATA_BITS-1], t[DATA_BITS-1], t} - {org[DATA_BITS-1], org[DATA_BITS-1], org};
    ad = d[DATA_BITS+1] ? -d : d;
    ox = {org[DATA_BITS-1], org};
    aox = org[DATA_BITS-1] ? -ox : ox;
    item_next.t = t;
    item_next.w = w;
    item_next.neg_d = d[DATA_BITS+1];
    item_next.neg_o = org[DATA_BITS-1];
    item_next.inf = (t == STAMP_MIN) || (t == STAMP_MAX);
    item_next.dvd_d = ad[DVD_BITS-1:0];
    item_next.dvd_o = aox;
    item_next.rem_d = '0;
    item_next.rem_o = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= item_next;
  end

endmodule

### hw/rtl/tba_div_stage.sv
// One restoring remainder step for both the offset stamp and the origin.
module tba_div_stage
  import tba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  tba_item_t in_item,
  output logic      out_valid,
  output tba_item_t out_item
);

  logic [WIDTH_BITS:0] wx;
  logic [WIDTH_BITS:0] cand_d;
  logic [WIDTH_BITS:0] cand_o;
  tba_item_t           item_next;

  always_comb begin
    wx = {1'b0, in_item.w};
    cand_d = {in_item.rem_d, in_item.dvd_d[DVD_BITS-1]};
    cand_o = {in_item.rem_o, in_item.dvd_o[DVD_BITS-1]};
    item_next = in_item;
    item_next.dvd_d = {in_item.dvd_d[DVD_BITS-2:0], 1'b0};
    item_next.dvd_o = {in_item.dvd_o[DVD_BITS-2:0], 1'b0};
    item_next.rem_d = (cand_d >= wx) ? WIDTH_BITS'(cand_d - wx) : WIDTH_BITS'(cand_d);
    item_next.rem_o = (cand_o >= wx) ? WIDTH_BITS'(cand_o - wx) : WIDTH_BITS'(cand_o);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= item_next;
  end

endmodule

### hw/rtl/tba_back.sv
// Output stages: remainder sign fixup, range checks and bucket start.
module tba_back
  import tba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tba_item_t            in_item,
  output logic                 done,
  output logic [DATA_BITS-1:0] bucket_start,
  output logic                 status
);

  logic                  fix_valid;
  logic [DATA_BITS-1:0]  fix_t;
  logic [DATA_BITS-1:0]  fix_o;
  logic [WIDTH_BITS-1:0] fix_r;
  logic                  fix_inf;
  logic [DATA_BITS-1:0]  o_next;
  logic [WIDTH_BITS-1:0] r_next;
  logic [DATA_BITS-1:0]  room;
  logic [DATA_BITS-1:0]  head;
  logic                  bad;

  always_comb begin
    o_next = in_item.neg_o ? -{1'b0, in_item.rem_o} : {1'b0, in_item.rem_o};
    r_next = (in_item.neg_d && (in_item.rem_d != '0)) ? in_item.w - in_item.rem_d
                                                       : in_item.rem_d;
  end

  always_comb begin
    room = fix_t - STAMP_MIN;
    head = STAMP_MAX - fix_t;
    bad = (!fix_o[DATA_BITS-1] && (fix_o != '0) && (room < fix_o)) ||
          (fix_o[DATA_BITS-1] && (head < -fix_o)) ||
          ({1'b0, fix_r} > room);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      fix_valid <= in_valid;
      done <= fix_valid;
    end
    fix_t <= in_item.t;
    fix_o <= o_next;
    fix_r <= r_next;
    fix_inf <= in_item.inf;
    if (fix_inf) begin
      bucket_start <= fix_t;
      status <= 1'b0;
    end else if (bad) begin
      bucket_start <= '0;
      status <= 1'b1;
    end else begin
      bucket_start <= fix_t - {1'b0, fix_r};
      status <= 1'b0;
    end
  end

endmodule

### hw/rtl/timestamp_bucket_align_top.sv
// Top level of the timestamp bucket alignment pipeline.
//
//   channel   signals                          handshake
//   command   start, busy, stamp               word taken when start and not busy
//   result    done, bucket_start, status       one-cycle strobe, no back-pressure
//   config    wr_en, wr_index, wr_data         write on any edge with wr_en
//
// One word enters per cycle; each result passes the input stage, the bit-serial
// remainder chain (one stage per dividend bit) and the output stages.
// busy is always low since the receiver cannot stall the pipeline.
// Reset restores width 1 and origin 0 and empties the pipeline.
module timestamp_bucket_align_top
  import tba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_BITS-1:0]  stamp,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_index,
  input  logic [DATA_BITS-1:0]  wr_data,
  output logic                  done,
  output logic [DATA_BITS-1:0]  bucket_start,
  output logic                  status
);

  logic [WIDTH_BITS-1:0] bucket_width;
  logic [DATA_BITS-1:0]  bucket_origin;
  logic                  stg_valid [DVD_BITS+1];
  tba_item_t             stg_item  [DVD_BITS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width <= WIDTH_BITS'(1);
      bucket_origin <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_WIDTH) begin
        bucket_width <= wr_data[WIDTH_BITS-1:0];
      end else if (wr_index == REG_ORIGIN) begin
        bucket_origin <= wr_data;
      end
    end
  end

  tba_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .stamp      (stamp),
    .width_cfg  (bucket_width),
    .origin_cfg (bucket_origin),
    .out_valid  (stg_valid[0]),
    .out_item   (stg_item[0])
  );

  for (genvar i = 0; i < DVD_BITS; i++) begin : g_div
    tba_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_item   (stg_item[i]),
      .out_valid (stg_valid[i+1]),
      .out_item  (stg_item[i+1])
    );
  end

  tba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stg_valid[DVD_BITS]),
    .in_item      (stg_item[DVD_BITS]),
    .done         (done),
    .bucket_start (bucket_start),
    .status       (status)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("result strobe missing after accepted word");
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(start && !busy, PIPE_DEPTH)) |-> $past(rst, PIPE_DEPTH))
    else $error("result strobe without an accepted word");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (bucket_start == '0))
    else $error("out-of-range result carries a nonzero start");
`endif

endmodule

### tb/tb_top.sv
// Testbench for the timestamp bucket alignment block: queued command driver, result checker.
`timescale 1ns / 1ps

module tb_top;
  import tba_pkg::*;

  localparam int LATENCY = 68;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [63:0] bucket;
    logic        stat;
  } bucket_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [DATA_BITS-1:0]  stamp = '0;
  logic                  wr_en = 1'b0;
  logic [INDEX_BITS-1:0] wr_index = '0;
  logic [DATA_BITS-1:0]  wr_data = '0;
  logic                  done;
  logic [DATA_BITS-1:0]  bucket_start;
  logic                  status;

  logic [62:0] cur_width = 63'd1;
  logic [63:0] cur_origin = 64'd0;

  logic [63:0]    pending_stamps[$];
  bucket_result_t expected_buckets[$];
  int             errors = 0;
  int             checked = 0;
  int             out_of_range = 0;
  int             gap_left = 0;
  longint         cycles = 0;
  bit             feeding = 1'b0;
  bit             hold_off = 1'b0;

  timestamp_bucket_align_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bucket_result_t align_stamp(logic [63:0] t_raw);
    bucket_result_t res;
    longint signed t, w, o, d, r;
    logic [63:0] room;
    t = $signed(t_raw);
    w = $signed({1'b0, cur_width});
    if (w == 0) w = 1;
    res.stat = 1'b0;
    res.bucket = t_raw;
    if (t_raw == STAMP_MIN || t_raw == STAMP_MAX) return res;
    o = $signed(cur_origin) % w;
    if ((o > 0 && t < $signed(STAMP_MIN) + o) || (o < 0 && t > $signed(STAMP_MAX) + o)) begin
      res.bucket = '0;
      res.stat = 1'b1;
      return res;
    end
    d = t - o;
    r = d % w;
    if (r < 0) r += w;
    room = t_raw - STAMP_MIN;
    if (64'(r) > room) begin
      res.bucket = '0;
      res.stat = 1'b1;
      return res;
    end
    res.bucket = t_raw - 64'(r);
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (!rst && feeding && !hold_off && pending_stamps.size() > 0 && gap_left == 0
        && !(start && busy)) begin
      if (!start || !busy) begin
        stamp <= pending_stamps[0];
        expected_buckets.push_back(align_stamp(pending_stamps[0]));
        void'(pending_stamps.pop_front());
        start <= 1'b1;
        gap_left <= pick_gap();
      end
    end else begin
      if (!(start && busy)) start <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_buckets.size() == 0) begin
        $display("%0t: unexpected result bucket_start=%h status=%b", $time, bucket_start,
                 status);
        errors++;
      end else begin
        if (bucket_start !== expected_buckets[0].bucket) begin
          $display("%0t: bucket_start expected %h actual %h", $time,
                   expected_buckets[0].bucket, bucket_start);
          errors++;
        end
        if (status !== expected_buckets[0].stat) begin
          $display("%0t: status expected %b actual %b", $time, expected_buckets[0].stat,
                   status);
          errors++;
        end
        if (expected_buckets[0].stat) out_of_range++;
        checked++;
        void'(expected_buckets.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [63:0] value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    if (idx == REG_WIDTH) cur_width = value[62:0];
    else cur_origin = value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_stamps.size() == 0);
    @(posedge clk);
    feeding = 1'b0;
    while (expected_buckets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_directed();
    logic [63:0] w;
    w = {1'b0, cur_width};
    pending_stamps.push_back(STAMP_MIN);
    pending_stamps.push_back(STAMP_MAX);
    pending_stamps.push_back(STAMP_MIN + 1);
    pending_stamps.push_back(STAMP_MAX - 1);
    pending_stamps.push_back(64'd0);
    pending_stamps.push_back(-64'sd1);
    pending_stamps.push_back(cur_origin);
    pending_stamps.push_back(cur_origin - 1);
    pending_stamps.push_back(cur_origin + w);
    pending_stamps.push_back(STAMP_MIN + 2);
  endtask

  task automatic add_random(int n);
    logic [63:0] v;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: v = rand64();
        1: v = cur_origin + 64'($signed($urandom_range(0, 2000)) - 1000);
        2: v = STAMP_MIN + 64'($urandom_range(1, 3000));
        3: v = STAMP_MAX - 64'($urandom_range(1, 3000));
        default: v = {{32{$urandom_range(0, 1) == 1}}, $urandom()};
      endcase
      pending_stamps.push_back(v);
    end
  endtask

  initial begin
    logic [63:0] widths[8];
    logic [63:0] origins[8];
    widths = '{64'd1, 64'd0, 64'h7fff_ffff_ffff_ffff, 64'd7, 64'd1000000, 64'hffff_ffff_ffff_ffff,
               64'd3600000000, 64'h4000_0000_0000_0001};
    origins = '{64'd0, 64'd5, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                -64'sd3, 64'd123456789, -64'sd999999, 64'h8000_0000_0000_0001};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    run_phase();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_WIDTH, p < 6 && p > 2 ? widths[p] : widths[p]);
      write_reg(REG_ORIGIN, origins[p]);
      add_directed();
      add_random(p == 4 ? 25 : 35);
      if (p == 3) begin
        feeding = 1'b1;
        wait (pending_stamps.size() < 20);
        hold_off = 1'b1;
        while (expected_buckets.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase();
    end
    write_reg(REG_WIDTH, {$urandom(), $urandom()});
    write_reg(REG_ORIGIN, rand64());
    add_random(40);
    run_phase();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results over 10 width/origin settings, %0d out of range.", checked,
             out_of_range);
    if (errors == 0 && expected_buckets.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
